// File: sv/iwn_pkg.sv
package iwn_pkg;

   // width of a running day count from biased year 0
   localparam int CountWidth = 23;
   // biased year: input year plus 400, never below 400
   localparam int YearWidth  = 15;
   localparam int YearBias   = 400;

   typedef struct packed {
      logic [13:0] calendar_year;
      logic [3:0]  month_number;
      logic [4:0]  day_of_month;
   } req_type;

   typedef struct packed {
      logic [5:0]  week_number;
      logic [13:0] week_year;
      logic [2:0]  weekday_number;
   } rsp_type;

   // day count handed from the date counter to the week calculator
   typedef struct packed {
      logic [CountWidth-1:0] count;      // days from biased year 0, day 1 = 0
      logic [CountWidth-1:0] year_start; // day count of 1 January of the year
      logic [YearWidth-1:0]  year;       // biased year
      logic                  leap_year;  // year is a leap year
      logic                  leap_prev;  // year before is a leap year
   } day_count_type;

   // days before the first of each month in a common year, by month index 0..11
   function automatic logic [8:0] days_before_month(input logic [3:0] idx);
      logic [8:0] d;
      unique case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: sv/iwn_day_count.sv
module iwn_day_count (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  iwn_pkg::req_type       in_word,
   output logic                   out_valid,
   input  logic                   out_stall,
   output iwn_pkg::day_count_type out_word
);
   import iwn_pkg::*;

   typedef struct packed {
      logic [YearWidth-1:0] year;
      logic [25:0]          prod_year; // (year/4) * 5243
      logic [25:0]          prod_prev; // ((year-1)/4) * 5243
      logic [8:0]           month_days;
      logic [4:0]           day;
      logic                 past_feb;
   } stage_a_type;

   typedef struct packed {
      logic [CountWidth-1:0] year_start;
      logic [YearWidth-1:0]  year;
      logic [8:0]            month_days;
      logic [4:0]            day;
      logic                  past_feb;
      logic                  leap_year;
      logic                  leap_prev;
   } stage_b_type;

   logic          a_valid_ff, b_valid_ff, c_valid_ff;
   stage_a_type   a_ff, a_in;
   stage_b_type   b_ff, b_in;
   day_count_type c_ff, c_in;
   logic          a_ready, b_ready, c_ready;

   // a stage takes a new word when it is empty or its word moves on
   assign c_ready  = !c_valid_ff || !out_stall;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_stall = !a_ready;

   // stage A: clamp month, bias year, start the divide-by-100 multiplies
   always_comb begin
      logic [YearWidth-1:0] y;
      logic [YearWidth-1:0] p;
      logic [3:0]           m;
      y = YearWidth'(in_word.calendar_year) + YearWidth'(YearBias);
      p = y - YearWidth'(1);
      priority if (in_word.month_number == 4'd0) begin
         m = 4'd0;
      end else if (in_word.month_number > 4'd12) begin
         m = 4'd11;
      end else begin
         m = in_word.month_number - 4'd1;
      end
      a_in.year       = y;
      a_in.prod_year  = 26'(y[YearWidth-1:2]) * 26'd5243;
      a_in.prod_prev  = 26'(p[YearWidth-1:2]) * 26'd5243;
      a_in.month_days = days_before_month(m);
      a_in.day        = in_word.day_of_month;
      a_in.past_feb   = (m > 4'd1);
   end

   // stage B: quotients by 100 and 400, leap flags, start of year
   always_comb begin
      logic [YearWidth-1:0] p;
      logic [7:0]           q_year, q_prev;
      logic [4:0]           r_year, r_prev;
      p      = a_ff.year - YearWidth'(1);
      q_year = a_ff.prod_year[24:17];
      q_prev = a_ff.prod_prev[24:17];
      r_year = 5'(a_ff.year[YearWidth-1:2] - 13'(q_year) * 13'd25);
      r_prev = 5'(p[YearWidth-1:2] - 13'(q_prev) * 13'd25);
      b_in.leap_year  = (a_ff.year[1:0] == 2'd0) &&
                        ((r_year != 5'd0) || (q_year[1:0] == 2'd0));
      b_in.leap_prev  = (p[1:0] == 2'd0) &&
                        ((r_prev != 5'd0) || (q_prev[1:0] == 2'd0));
      b_in.year_start = CountWidth'(a_ff.year) * CountWidth'(365)
                      + CountWidth'(p[YearWidth-1:2]) - CountWidth'(q_prev)
                      + CountWidth'(q_prev[7:2]) + CountWidth'(1);
      b_in.year       = a_ff.year;
      b_in.month_days = a_ff.month_days;
      b_in.day        = a_ff.day;
      b_in.past_feb   = a_ff.past_feb;
   end

   // stage C: day count, day 1 is offset zero
   always_comb begin
      c_in.count      = b_ff.year_start + CountWidth'(b_ff.month_days)
                      + CountWidth'(b_ff.day)
                      + CountWidth'(b_ff.past_feb && b_ff.leap_year)
                      - CountWidth'(1);
      c_in.year_start = b_ff.year_start;
      c_in.year       = b_ff.year;
      c_in.leap_year  = b_ff.leap_year;
      c_in.leap_prev  = b_ff.leap_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) a_ff <= a_in;
      if (b_ready) b_ff <= b_in;
      if (c_ready) c_ff <= c_in;
   end

   assign out_valid = c_valid_ff;
   assign out_word  = c_ff;

endmodule

// File: sv/iwn_week_calc.sv
module iwn_week_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  iwn_pkg::day_count_type in_word,
   output logic                   out_valid,
   input  logic                   out_stall,
   output iwn_pkg::rsp_type       out_word
);
   import iwn_pkg::*;

   typedef struct packed {
      day_count_type dc;
      logic [2:0]    wd; // weekday, Monday = 0
   } stage_d_type;

   typedef struct packed {
      logic [8:0]           diff; // days from 1 January of week year to Thursday
      logic [YearWidth-1:0] week_year;
      logic [2:0]           wd;
   } stage_e_type;

   // residue mod 7 by folding 3-bit digits (8 = 1 mod 7)
   function automatic logic [2:0] mod7(input logic [23:0] x);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      s1 = 6'd0;
      for (int i = 0; i < 8; i++) begin
         s1 = s1 + 6'(x[3*i +: 3]);
      end
      s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
      s3 = 3'(s2[3]) + s2[2:0];
      return (s3 == 3'd7) ? 3'd0 : s3;
   endfunction

   logic        d_valid_ff, e_valid_ff, f_valid_ff;
   stage_d_type d_ff, d_in;
   stage_e_type e_ff, e_in;
   rsp_type     f_ff, f_in;
   logic        d_ready, e_ready, f_ready;
   logic [23:0] sel_diff;

   assign f_ready  = !f_valid_ff || !out_stall;
   assign e_ready  = !e_valid_ff || f_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign in_stall = !d_ready;

   // stage D: weekday; biased year 0 opens on a Saturday
   always_comb begin
      d_in.dc = in_word;
      d_in.wd = mod7(24'(in_word.count) + 24'd5);
   end

   // stage E: Thursday of the week picks the week year
   always_comb begin
      logic [23:0] thursday, d_same, d_next, d_prev;
      thursday = 24'(d_ff.dc.count) - 24'(d_ff.wd) + 24'd3;
      d_same   = thursday - 24'(d_ff.dc.year_start);
      d_next   = d_same - 24'd365 - 24'(d_ff.dc.leap_year);
      d_prev   = d_same + 24'd365 + 24'(d_ff.dc.leap_prev);
      priority if (d_same[23]) begin
         sel_diff     = d_prev;
         e_in.week_year = d_ff.dc.year - YearWidth'(1);
      end else if (!d_next[23]) begin
         sel_diff     = d_next;
         e_in.week_year = d_ff.dc.year + YearWidth'(1);
      end else begin
         sel_diff     = d_same;
         e_in.week_year = d_ff.dc.year;
      end
      e_in.diff = sel_diff[8:0];
      e_in.wd   = d_ff.wd;
   end

   // stage F: week = diff / 7 + 1 by reciprocal, exact below 682
   always_comb begin
      logic [17:0]          prod;
      logic [YearWidth-1:0] wy;
      prod  = 18'(e_ff.diff) * 18'd293;
      wy    = e_ff.week_year - YearWidth'(YearBias);
      f_in.week_number    = 6'(prod[16:11]) + 6'd1;
      f_in.week_year      = wy[13:0];
      f_in.weekday_number = e_ff.wd + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (d_ready) d_valid_ff <= in_valid;
         if (e_ready) e_valid_ff <= d_valid_ff;
         if (f_ready) f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready) d_ff <= d_in;
      if (e_ready) e_ff <= e_in;
      if (f_ready) f_ff <= f_in;
   end

   assign out_valid = f_valid_ff;
   assign out_word  = f_ff;

   // Thursday lands inside the chosen week year
   a_diff_in_year: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> (sel_diff < 24'd366))
      else $error("Thursday offset outside week year");

   a_week_range: assert property (@(posedge clock) disable iff (reset)
      f_valid_ff |-> (f_ff.week_number >= 6'd1 && f_ff.week_number <= 6'd53))
      else $error("week number out of range");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      f_valid_ff |-> (f_ff.weekday_number != 3'd0))
      else $error("weekday out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !f_valid_ff && !e_valid_ff && !d_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// File: sv/iso_week_number.sv
// ISO 8601 week date of a Gregorian date.
// Request channel (req_valid / req_stall / req_word): one date per word,
// year, month and day. A word is taken at a clock edge with req_valid high
// and req_stall low. Month zero reads as January, months above twelve as
// December, and days past the month's end roll into the next month.
// Response channel (rsp_valid / rsp_stall / rsp_word): week number, week
// year and weekday (Monday = 1) for each date, in request order.
// A request passes through the registers of stages A to F, in that order,
// before its result shows on rsp_valid and rsp_word.
// Throughput: one date per cycle while rsp_stall stays low, set by a
// six-stage pipeline (stages A to F).
// Stalls: a stage that holds a word keeps it while the stage after is full
// and stalled; empty stages still fill, so with rsp_stall held the block
// takes up to six more words before req_stall rises.
// Reset (synchronous, active high) empties the pipeline, so req_stall is
// low and the block can take a request once reset falls.
module iso_week_number (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iwn_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iwn_pkg::rsp_type rsp_word
);
   import iwn_pkg::*;

   logic          mid_valid;
   logic          mid_stall;
   day_count_type mid_word;

   // date to running day count
   iwn_day_count u_day_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (req_word),
      .out_valid (mid_valid),
      .out_stall (mid_stall),
      .out_word  (mid_word)
   );

   // day count to weekday, week year and week
   iwn_week_calc u_week_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_stall  (mid_stall),
      .in_word   (mid_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   import iwn_pkg::*;

   localparam int unsigned BiasYears = 400;
   localparam int unsigned HoldCycles = 40;
   // days before the first of each month in a common year
   localparam int unsigned MonthStart[12] = '{0, 31, 59, 90, 120, 151,
                                             181, 212, 243, 273, 304, 334};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   req_type     pending_dates[$];
   rsp_type     due_weeks[$];
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned words_sent = 0;
   int unsigned hold_at = 32'hFFFF_FFFF;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned mismatch_count = 0;

   iso_week_number dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // day count of 1 January of biased year y
   function automatic int unsigned jan_first(input int unsigned y);
      int unsigned p;
      if (y == 0) return 0;
      p = y - 1;
      return 365 * y + p / 4 - p / 100 + p / 400 + 1;
   endfunction

   function automatic bit gregorian_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // ISO week date of one request word
   function automatic rsp_type iso_week_of(input req_type d);
      int unsigned mon, by, count, wd, thu, wy, wk, wy_out;
      rsp_type r;
      mon = 32'(d.month_number);
      if (mon < 1) mon = 1;
      if (mon > 12) mon = 12;
      by = int'(d.calendar_year) + BiasYears;
      count = jan_first(by) + MonthStart[mon - 1] + 32'(d.day_of_month);
      if (mon > 2 && gregorian_leap(by)) count++;
      // day 1 is offset 0, day 0 reaches back into the month before
      count--;
      // biased year 0 began on a Saturday
      wd = (count + 5) % 7 + 1;
      // the Thursday of this Monday-based week fixes the week year
      thu = count - (wd - 1) + 3;
      wy = by;
      if (thu < jan_first(wy)) wy--;
      else if (thu >= jan_first(wy + 1)) wy++;
      wk = (thu - jan_first(wy)) / 7 + 1;
      wy_out = wy + 16384 - BiasYears;
      r.week_number    = wk[5:0];
      r.week_year      = wy_out[13:0];
      r.weekday_number = wd[2:0];
      return r;
   endfunction

   function automatic req_type random_date();
      req_type d;
      case ($urandom_range(9))
         0: begin
            // any bit pattern the fields allow
            d.calendar_year = 14'($urandom_range(16383));
            d.month_number  = 4'($urandom_range(15));
            d.day_of_month  = 5'($urandom_range(31));
         end
         1, 2: begin
            // near a year boundary, where the week year can differ
            d.calendar_year = 14'($urandom_range(1, 9999));
            if ($urandom_range(1)) begin
               d.month_number = 4'd1;
               d.day_of_month = 5'($urandom_range(0, 7));
            end else begin
               d.month_number = 4'd12;
               d.day_of_month = 5'($urandom_range(24, 31));
            end
         end
         default: begin
            d.calendar_year = 14'($urandom_range(1, 9999));
            d.month_number  = 4'($urandom_range(1, 12));
            if ($urandom_range(3) == 0) d.day_of_month = 5'($urandom_range(29, 31));
            else d.day_of_month = 5'($urandom_range(1, 28));
         end
      endcase
      return d;
   endfunction

   task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d);
      req_type w;
      w.calendar_year = 14'(y);
      w.month_number  = 4'(m);
      w.day_of_month  = 5'(d);
      pending_dates.push_back(w);
   endtask

   task automatic add_random(input int unsigned n);
      repeat (n) pending_dates.push_back(random_date());
   endtask

   // wait until every queued word has gone in and every result has come out
   task automatic drain_dates();
      while (pending_dates.size() != 0 || req_valid || due_weeks.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_weeks.push_back(iso_week_of(req_word));
            words_sent <= words_sent + 1;
         end
         if (req_valid && req_stall) begin
            // stalled word stays as it is
         end else if (pending_dates.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_valid <= 1'b1;
            req_word  <= pending_dates.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, started once the sent count reaches hold_at
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_sent >= hold_at) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end
   end

   // response monitor and receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_weeks.size() == 0) begin
               $error("unexpected result word: week %0d, year %0d, weekday %0d",
                      rsp_word.week_number, rsp_word.week_year, rsp_word.weekday_number);
               mismatch_count++;
            end else begin
               want = due_weeks.pop_front();
               if (rsp_word.week_number !== want.week_number) begin
                  $error("week_number: expected %0d, got %0d",
                         want.week_number, rsp_word.week_number);
                  mismatch_count++;
               end
               if (rsp_word.week_year !== want.week_year) begin
                  $error("week_year: expected %0d, got %0d",
                         want.week_year, rsp_word.week_year);
                  mismatch_count++;
               end
               if (rsp_word.weekday_number !== want.weekday_number) begin
                  $error("weekday_number: expected %0d, got %0d",
                         want.weekday_number, rsp_word.weekday_number);
                  mismatch_count++;
               end
            end
         end
         if (hold_left != 0) rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // stimulus; reset falls at a rising edge, all else changes on the falling edge
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // phase one: sender rarely idles, receiver mostly stalls
      tx_idle_pct = 9;
      rx_idle_pct = 86;
      add_date(1, 1, 1);          // first year of the range
      add_date(9999, 12, 31);     // last year of the range
      add_date(0, 1, 1);          // year zero, a leap year
      add_date(0, 0, 0);          // week year below zero wraps
      add_date(16383, 12, 31);    // largest year field
      add_date(16383, 15, 31);    // month above twelve, week year may wrap
      add_date(2021, 1, 1);       // week 53 of the year before
      add_date(2021, 1, 3);
      add_date(2021, 1, 4);
      add_date(2024, 12, 30);     // week 1 of the year after
      add_date(2024, 12, 31);
      add_date(2020, 12, 31);     // week 53
      add_date(2024, 2, 29);      // leap day
      add_date(2023, 2, 29);      // rolls into March in a common year
      add_date(2024, 2, 30);      // rolls into March in a leap year
      add_date(1900, 3, 1);       // century, not leap
      add_date(2000, 3, 1);       // fourth century, leap
      add_date(2022, 0, 15);      // month zero reads as January
      add_date(2022, 13, 15);     // month above twelve reads as December
      add_date(2022, 3, 0);       // day zero, last day of February
      add_date(2022, 4, 31);      // day past the month's end
      add_date(2022, 1, 31);
      add_date(8191, 6, 16);
      add_date(8192, 9, 1);
      add_random(360);
      drain_dates();

      // phase two: the other way round
      tx_idle_pct = 86;
      rx_idle_pct = 9;
      add_random(380);
      drain_dates();

      // phase three: no idling, with one long receiver hold-off
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_at = words_sent + 50;
      add_random(385);
      drain_dates();

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && due_weeks.size() == 0) begin
         $display("** iso_week_number: PASSED **");
      end else begin
         $display("** iso_week_number: FAILED **");
      end
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("** iso_week_number: FAILED **");
      $finish;
   end

endmodule
